FILE: rtl/nugg_pkg.sv
// Package with shared types and constants for the non-uniform grid gradient block.
`timescale 1ns / 1ps
package nugg_pkg;

    localparam int DataWidthDef = 32;
    localparam int FracBitsDef  = 16;

    // Job kinds handed from the front part to the back part.
    typedef enum logic [2:0] {
        JOB_SINGLE   = 3'b001,
        JOB_FORWARD  = 3'b010,
        JOB_INTERIOR = 3'b100
    } t_job_kind;

    // One input transfer.
    typedef struct packed {
        logic signed [31:0] sample_value;
        logic signed [31:0] coordinate;
        logic               final_sample;
    } t_in_item;

    // One result transfer.
    typedef struct packed {
        logic signed [31:0] derivative;
        logic               zero_spacing;
        logic               last_result;
    } t_out_item;

endpackage

FILE: rtl/nugg_front.sv
// Front part: keeps the two prior points and turns each input into difference jobs.
`timescale 1ns / 1ps
module nugg_front
    import nugg_pkg::*;
#(
    parameter int DW = DataWidthDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_value,
    input  logic [DW-1:0]     i_coord,
    input  logic              i_final,
    output logic              o_ready,
    // Job output: kind, last flag, four differences.
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output t_job_kind         o_job_kind,
    output logic              o_job_last,
    output logic [DW:0]       o_job_a,
    output logic [DW:0]       o_job_b,
    output logic [DW:0]       o_job_c,
    output logic [DW:0]       o_job_d
);

    logic [DW-1:0] r_v0, r_v1, r_x0, r_x1;
    logic [1:0]    r_seen;
    logic          r_pend;
    logic [DW-1:0] r_pv, r_px;

    logic          w_take;
    logic          w_emit;
    logic          w_pend_go;
    logic          w_job_load;

    // A final point that follows at least one point yields two jobs; the second waits in r_pend.
    assign o_ready    = !r_pend && (!o_job_valid || i_job_ready);
    assign w_take     = i_valid && o_ready;
    assign w_emit     = o_job_valid && i_job_ready;
    assign w_pend_go  = r_pend && (!o_job_valid || i_job_ready);
    assign w_job_load = w_pend_go || (w_take && (r_seen != 2'd0 || i_final));

    function automatic logic [DW:0] sdiff(input logic [DW-1:0] a, input logic [DW-1:0] b);
        sdiff = {a[DW-1], a} - {b[DW-1], b};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 2'd0;
            r_pend      <= 1'b0;
            o_job_valid <= 1'b0;
        end else begin
            if (w_job_load) begin
                o_job_valid <= 1'b1;
            end else if (w_emit) begin
                o_job_valid <= 1'b0;
            end
            if (w_pend_go) begin
                o_job_kind  <= JOB_FORWARD;
                o_job_last  <= 1'b1;
                o_job_a     <= sdiff(r_pv, r_v0);
                o_job_c     <= sdiff(r_px, r_x0);
                r_pend      <= 1'b0;
                r_seen      <= 2'd0;
            end else if (w_take) begin
                if (r_seen == 2'd0) begin
                    if (i_final) begin
                        o_job_kind  <= JOB_SINGLE;
                        o_job_last  <= 1'b1;
                    end else begin
                        r_v0   <= i_value;
                        r_x0   <= i_coord;
                        r_seen <= 2'd1;
                    end
                end else begin
                    o_job_last  <= 1'b0;
                    o_job_kind  <= (r_seen == 2'd1) ? JOB_FORWARD : JOB_INTERIOR;
                    o_job_a     <= sdiff(i_value, r_v0);
                    o_job_b     <= sdiff(r_v0, r_v1);
                    o_job_c     <= sdiff(i_coord, r_x0);
                    o_job_d     <= sdiff(r_x0, r_x1);
                    if (i_final) begin
                        r_pend <= 1'b1;
                        r_pv   <= i_value;
                        r_px   <= i_coord;
                    end else begin
                        r_v1   <= r_v0;
                        r_x1   <= r_x0;
                        r_v0   <= i_value;
                        r_x0   <= i_coord;
                        r_seen <= 2'd2;
                    end
                end
            end
        end
    end

    // Checks on the front's own bookkeeping.
    a_pend_needs_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_seen != 2'd0) else $error("pending final without prior point");
    a_pend_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_ready) else $error("input taken while a job is pending");
    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen != 2'd3) else $error("point count out of range");

endmodule

FILE: rtl/nugg_back.sv
// Back part: sequenced multiplies and a shared radix-2 divider per job.
`timescale 1ns / 1ps
module nugg_back
    import nugg_pkg::*;
#(
    parameter int DW = DataWidthDef,
    parameter int FB = FracBitsDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  t_job_kind     i_job_kind,
    input  logic          i_job_last,
    input  logic [DW:0]   i_job_a,
    input  logic [DW:0]   i_job_b,
    input  logic [DW:0]   i_job_c,
    input  logic [DW:0]   i_job_d,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output logic [DW-1:0] o_res_deriv,
    output logic          o_res_zero,
    output logic          o_res_last
);

    // Differences are DW+1 bits signed and squares 2*DW bits, never negative.
    // Numerator and denominator stay well inside NW bits signed.
    localparam int EW = DW + 1;
    localparam int SW = 2 * DW;
    localparam int NW = 3 * EW + 2;
    localparam int QW = NW + FB;
    localparam int CW = $clog2(QW + 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_M1   = 7'b0000010,
        ST_M2   = 7'b0000100,
        ST_M3   = 7'b0001000,
        ST_PREP = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_job_kind r_kind;
    logic r_last;
    logic signed [EW-1:0] r_a, r_b, r_c, r_d;
    logic [SW-1:0] r_hs2, r_hd2;
    logic [2:0] r_step;
    logic signed [NW-1:0] r_num, r_den;
    logic [QW-1:0] r_dividend, r_q;
    logic [NW-1:0] r_rem, r_dmag;
    logic r_neg;
    logic [CW-1:0] r_cnt;

    // One shared multiplier: the two squares, then eight partial products.
    // The numerator is hs^2*dp + hd^2*dm and the denominator hs^2*hd + hd^2*hs;
    // each square is taken in two halves so the multiplier stays narrow.
    logic signed [EW-1:0]   w_ma, w_mb;
    logic signed [2*EW-1:0] w_prod;
    logic [SW-1:0]          w_sq;
    logic signed [NW-1:0]   w_ext, w_term;
    always_comb begin
        w_sq = r_step[1] ? r_hd2 : r_hs2;
        case (r_state)
            ST_M1: begin
                w_ma = r_d;
                w_mb = r_d;
            end
            ST_M2: begin
                w_ma = r_c;
                w_mb = r_c;
            end
            ST_M3: begin
                w_ma = {1'b0, (r_step[0] ? w_sq[SW-1:DW] : w_sq[DW-1:0])};
                w_mb = r_step[2] ? (r_step[1] ? r_d : r_c) : (r_step[1] ? r_b : r_a);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
        w_ext  = NW'(w_prod);
        w_term = r_step[0] ? (w_ext << DW) : w_ext;
    end

    logic [NW:0] w_trial;
    logic [NW-1:0] w_rsh;
    assign w_rsh   = {r_rem[NW-2:0], r_dividend[QW-1]};
    assign w_trial = {1'b0, w_rsh} - {1'b0, r_dmag};

    logic [DW-1:0] w_lim, w_sat;
    logic          w_over;
    assign w_lim  = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    assign w_over = (r_q[QW-1:DW-1] != '0) && !(r_neg && r_q[QW-1:DW-1] == 1
                    && r_q[DW-2:0] == '0);
    assign w_sat  = w_over ? w_lim : (r_neg ? DW'(-r_q[DW-1:0]) : r_q[DW-1:0]);

    assign o_job_ready = (r_state == ST_IDLE);

    // A result is loaded when the output register is free or being emptied.
    logic w_res_load;
    assign w_res_load = (r_state == ST_OUT) && (!o_res_valid || i_res_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            o_res_valid <= 1'b0;
        end else begin
            if (w_res_load) begin
                o_res_valid <= 1'b1;
            end else if (o_res_valid && i_res_ready) begin
                o_res_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: if (i_job_valid) begin
                    r_kind <= i_job_kind;
                    r_last <= i_job_last;
                    r_a <= i_job_a; r_b <= i_job_b;
                    r_c <= i_job_c; r_d <= i_job_d;
                    r_state <= (i_job_kind == JOB_INTERIOR) ? ST_M1 : ST_PREP;
                    r_num <= NW'(signed'(i_job_a));
                    r_den <= NW'(signed'(i_job_c));
                end
                ST_M1: begin
                    r_hs2   <= w_prod[SW-1:0];
                    r_num   <= '0;
                    r_den   <= '0;
                    r_step  <= '0;
                    r_state <= ST_M2;
                end
                ST_M2: begin
                    r_hd2   <= w_prod[SW-1:0];
                    r_state <= ST_M3;
                end
                ST_M3: begin
                    if (r_step[2]) begin
                        r_den <= r_den + w_term;
                    end else begin
                        r_num <= r_num + w_term;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd7) r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_neg      <= r_num[NW-1] ^ r_den[NW-1];
                    r_dividend <= {(r_num[NW-1] ? -r_num : r_num), {FB{1'b0}}};
                    r_dmag     <= r_den[NW-1] ? -r_den : r_den;
                    r_rem      <= '0;
                    r_q        <= '0;
                    r_cnt      <= CW'(QW);
                    r_state    <= (r_kind == JOB_SINGLE || r_den == '0) ? ST_OUT : ST_DIV;
                end
                ST_DIV: begin
                    r_dividend <= r_dividend << 1;
                    if (!w_trial[NW]) begin
                        r_rem <= w_trial[NW-1:0];
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rsh;
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) r_state <= ST_OUT;
                end
                ST_OUT: if (w_res_load) begin
                    o_res_last  <= r_last;
                    o_res_zero  <= (r_kind == JOB_SINGLE) || (r_dmag == '0);
                    o_res_deriv <= (r_kind == JOB_SINGLE || r_dmag == '0) ? '0 : w_sat;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_cnt != '0) else $error("divider overran");
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) && o_res_zero |-> o_res_deriv == '0)
        else $error("zero flag with nonzero result");

endmodule

FILE: rtl/nonuniform_grid_gradient.sv
// Top level of the non-uniform grid gradient block.
// Each job runs through the back part alone: an interior point adds two square and
// eight partial-product steps before the bit-serial divider, and the back part takes no
// new job until its result is loaded; the queue between parts holds one job, and a final
// point after at least one point makes a second job behind the first.
// Reset: synchronous active low; clears point count, job queue and result valid.
`timescale 1ns / 1ps
module nonuniform_grid_gradient
    import nugg_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    localparam int DW = DataWidthDef;

    logic        w_jv, w_jr, w_jl, w_rv;
    t_job_kind   w_jk;
    logic [DW:0] w_a, w_b, w_c, w_d;
    logic [DW-1:0] w_der;
    logic        w_rdy, w_z, w_l;

    nugg_front #(.DW(DW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(push),
        .i_value(i_item.sample_value), .i_coord(i_item.coordinate),
        .i_final(i_item.final_sample), .o_ready(w_rdy),
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job_kind(w_jk), .o_job_last(w_jl),
        .o_job_a(w_a), .o_job_b(w_b), .o_job_c(w_c), .o_job_d(w_d)
    );

    nugg_back #(.DW(DW), .FB(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(w_jv), .o_job_ready(w_jr),
        .i_job_kind(w_jk), .i_job_last(w_jl),
        .i_job_a(w_a), .i_job_b(w_b), .i_job_c(w_c), .i_job_d(w_d),
        .o_res_valid(w_rv), .i_res_ready(pop), .o_res_deriv(w_der),
        .o_res_zero(w_z), .o_res_last(w_l)
    );

    assign full  = !w_rdy;
    assign empty = !w_rv;
    assign o_item.derivative   = w_der;
    assign o_item.zero_spacing = w_z;
    assign o_item.last_result  = w_l;

endmodule
